// ===== rtl/x86e_pkg.sv =====
// Package: widths, opcode fields, status and ALU codes for the 16-bit x86 executor.
`default_nettype none

package x86e_pkg;

    localparam int WORD_W           = 16;
    localparam int BYTE_W           = 8;
    localparam int DEFAULT_NUM_REGS = 4;
    localparam int IN_DATA_W        = 24;
    localparam int OUT_DATA_W       = 80;
    localparam int STATUS_W         = 2;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [2:0]          reg_code_t;
    typedef logic [1:0]          alu_op_t;

    typedef struct packed {
        word_t pc;
        logic  halted;
    } ctl_t;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_EXIT = 2'd1;
    localparam status_t ST_BAD  = 2'd2;

    localparam alu_op_t ALU_MOV = 2'd0;
    localparam alu_op_t ALU_ADD = 2'd1;
    localparam alu_op_t ALU_SUB = 2'd2;

    localparam reg_code_t REG_AX = 3'd0;
    localparam reg_code_t REG_CX = 3'd1;

    // opcode group prefixes
    localparam logic [4:0] OPC_MOV_R8_IMM  = 5'b10110;   // B0..B7
    localparam logic [4:0] OPC_MOV_R16_IMM = 5'b10111;   // B8..BF
    localparam logic [5:0] OPC_MOV_MODRM   = 6'b100010;  // 88..8B
    localparam logic [5:0] OPC_ADD_MODRM   = 6'b000000;  // 00..03
    localparam logic [5:0] OPC_SUB_MODRM   = 6'b001010;  // 28..2B

    localparam byte_t OPC_ADD_AL_IMM = 8'h04;
    localparam byte_t OPC_ADD_AX_IMM = 8'h05;
    localparam byte_t OPC_SUB_AL_IMM = 8'h2C;
    localparam byte_t OPC_SUB_AX_IMM = 8'h2D;
    localparam byte_t OPC_LOOP       = 8'hE2;
    localparam byte_t OPC_INT        = 8'hCD;
    localparam byte_t INT_EXIT_VEC   = 8'h20;

    localparam logic [1:0] MOD_REG = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/x86e_exec.sv =====
// Execute unit: decodes one instruction and forms the next register file, pc and status.
`default_nettype none

module x86e_exec #(
    parameter int NUM_REGS = x86e_pkg::DEFAULT_NUM_REGS
) (
    input  wire x86e_pkg::byte_t                        opcode,
    input  wire x86e_pkg::byte_t                        opnd1,
    input  wire x86e_pkg::byte_t                        opnd2,
    input  wire [NUM_REGS-1:0][x86e_pkg::WORD_W-1:0]    rf,
    input  wire x86e_pkg::ctl_t                         ctl,
    output logic [NUM_REGS-1:0][x86e_pkg::WORD_W-1:0]   rf_next,
    output x86e_pkg::ctl_t                              ctl_next,
    output x86e_pkg::status_t                           status
);
    import x86e_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    function automatic byte_t byte_of(input word_t w, input logic hi);
        begin
            byte_of = hi ? w[15:8] : w[7:0];
        end
    endfunction

    reg_code_t  reg_c;
    reg_code_t  rm_c;
    reg_code_t  dst_c;
    reg_code_t  src_c;
    reg_code_t  wr_code;
    logic       dst_ok;
    logic       src_ok;
    logic       wr_en;
    logic       wr_wide;
    logic       is_loop;
    alu_op_t    alu_op;
    word_t      a_val;
    word_t      b_val;
    word_t      res;
    word_t      imm16;
    word_t      disp;
    logic [1:0] len;

    always_comb
    begin
        rf_next  = rf;
        ctl_next = ctl;
        status   = ST_OK;
        len      = 2'd0;
        reg_c    = opnd1[5:3];
        rm_c     = opnd1[2:0];
        dst_c    = opcode[1] ? reg_c : rm_c;
        src_c    = opcode[1] ? rm_c : reg_c;
        dst_ok   = 32'(dst_c) < NUM_REGS;
        src_ok   = 32'(src_c) < NUM_REGS;
        imm16    = {opnd2, opnd1};
        disp     = {{8{opnd1[7]}}, opnd1};
        wr_en    = 1'b0;
        wr_wide  = 1'b0;
        wr_code  = dst_c;
        is_loop  = 1'b0;
        alu_op   = ALU_MOV;
        a_val    = '0;
        b_val    = '0;

        if (ctl.halted)
        begin
            status = ST_EXIT;
        end
        else if (opcode[7:3] == OPC_MOV_R8_IMM)
        begin
            wr_en   = 1'b1;
            wr_code = opcode[2:0];
            b_val   = {8'h00, opnd1};
            len     = 2'd2;
        end
        else if (opcode[7:3] == OPC_MOV_R16_IMM)
        begin
            if (32'(opcode[2:0]) < NUM_REGS)
            begin
                wr_en   = 1'b1;
                wr_wide = 1'b1;
                wr_code = opcode[2:0];
                b_val   = imm16;
                len     = 2'd3;
            end
            else
            begin
                status = ST_BAD;
            end
        end
        else if (opcode[7:2] == OPC_MOV_MODRM || opcode[7:2] == OPC_ADD_MODRM
                 || opcode[7:2] == OPC_SUB_MODRM)
        begin
            alu_op = (opcode[7:2] == OPC_MOV_MODRM) ? ALU_MOV :
                     (opcode[7:2] == OPC_ADD_MODRM) ? ALU_ADD : ALU_SUB;
            if (opnd1[7:6] != MOD_REG)
            begin
                status = ST_BAD;
            end
            else if (opcode[0])
            begin
                if (dst_ok && src_ok)
                begin
                    wr_en   = 1'b1;
                    wr_wide = 1'b1;
                    a_val   = rf[IDX_W'(dst_c)];
                    b_val   = rf[IDX_W'(src_c)];
                    len     = 2'd2;
                end
                else
                begin
                    status = ST_BAD;
                end
            end
            else
            begin
                wr_en = 1'b1;
                a_val = {8'h00, byte_of(rf[IDX_W'(dst_c[1:0])], dst_c[2])};
                b_val = {8'h00, byte_of(rf[IDX_W'(src_c[1:0])], src_c[2])};
                len   = 2'd2;
            end
        end
        else if (opcode == OPC_ADD_AL_IMM || opcode == OPC_SUB_AL_IMM)
        begin
            wr_en   = 1'b1;
            wr_code = REG_AX;
            alu_op  = (opcode == OPC_ADD_AL_IMM) ? ALU_ADD : ALU_SUB;
            a_val   = {8'h00, rf[IDX_W'(REG_AX)][7:0]};
            b_val   = {8'h00, opnd1};
            len     = 2'd2;
        end
        else if (opcode == OPC_ADD_AX_IMM || opcode == OPC_SUB_AX_IMM)
        begin
            wr_en   = 1'b1;
            wr_wide = 1'b1;
            wr_code = REG_AX;
            alu_op  = (opcode == OPC_ADD_AX_IMM) ? ALU_ADD : ALU_SUB;
            a_val   = rf[IDX_W'(REG_AX)];
            b_val   = imm16;
            len     = 2'd3;
        end
        else if (opcode == OPC_LOOP)
        begin
            // decrement CX, then branch on the new value
            is_loop = 1'b1;
            wr_en   = 1'b1;
            wr_wide = 1'b1;
            wr_code = REG_CX;
            alu_op  = ALU_SUB;
            a_val   = rf[IDX_W'(REG_CX)];
            b_val   = 16'h0001;
        end
        else if (opcode == OPC_INT && opnd1 == INT_EXIT_VEC)
        begin
            ctl_next.halted = 1'b1;
            status          = ST_EXIT;
            len             = 2'd2;
        end
        else
        begin
            status = ST_BAD;
        end

        case (alu_op)
            ALU_MOV: res = b_val;
            ALU_ADD: res = a_val + b_val;
            ALU_SUB: res = a_val - b_val;
            default: res = b_val;
        endcase

        if (wr_en)
        begin
            if (wr_wide)
            begin
                rf_next[IDX_W'(wr_code)] = res;
            end
            else if (wr_code[2])
            begin
                rf_next[IDX_W'(wr_code[1:0])][15:8] = res[7:0];
            end
            else
            begin
                rf_next[IDX_W'(wr_code[1:0])][7:0] = res[7:0];
            end
        end

        if (is_loop)
        begin
            ctl_next.pc = ctl.pc + 16'd2 + ((res != '0) ? disp : 16'h0000);
        end
        else
        begin
            ctl_next.pc = ctl.pc + 16'(len);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/x86_16bit_register_executor.sv =====
// Top level: 16-bit x86 subset executor with input stage, state registers and result register.
//
//  channel | dir | payload
//  s_axis  | in  | tdata = opcode, first_operand_byte, second_operand_byte
//  m_axis  | out | tdata = next_pc, ax, cx, dx, bx; tuser = status
//
//  One instruction per cycle while m_axis_tready is high; each item is registered
//  in the input stage and then leaves from the result register.
//  The register file, pc and halt flag update in the same cycle as the decode.
//  Reset clears the registers, pc and halt flag; no clearing pass.
//  A stall on m_axis holds the input stage; s_axis_tready is high while that stage is empty or advances.
`default_nettype none

module x86_16bit_register_executor #(
    parameter int NUM_REGS = x86e_pkg::DEFAULT_NUM_REGS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] opcode, [15:8] first_operand_byte, [23:16] second_operand_byte
    input  wire [x86e_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [15:0] next_pc, [31:16] ax, [47:32] cx, [63:48] dx, [79:64] bx
    output logic [x86e_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output x86e_pkg::status_t                   m_axis_tuser
);
    import x86e_pkg::*;

    logic                              in_valid_reg;
    logic [IN_DATA_W-1:0]              in_data_reg;
    logic                              out_valid_reg;
    logic [OUT_DATA_W-1:0]             out_data_reg;
    status_t                           out_user_reg;
    logic [NUM_REGS-1:0][WORD_W-1:0]   rf_reg;
    ctl_t                              ctl_reg;

    logic [NUM_REGS-1:0][WORD_W-1:0]   rf_next;
    ctl_t                              ctl_next;
    status_t                           status_next;
    logic                              advance;
    logic                              in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    x86e_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .opcode   (in_data_reg[7:0]),
        .opnd1    (in_data_reg[15:8]),
        .opnd2    (in_data_reg[23:16]),
        .rf       (rf_reg),
        .ctl      (ctl_reg),
        .rf_next  (rf_next),
        .ctl_next (ctl_next),
        .status   (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_reg        <= '0;
            ctl_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                rf_reg        <= rf_next;
                ctl_reg       <= ctl_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= {rf_next[3], rf_next[2], rf_next[1], rf_next[0], ctl_next.pc};
            out_user_reg <= status_next;
        end
    end

    a_halt_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.halted |=> ctl_reg.halted)
        else $error("halt flag cleared");

    a_halted_exit : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctl_reg.halted) |=> (m_axis_tuser == ST_EXIT))
        else $error("item after exit not reported as exit");

    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(rf_reg) && $stable(ctl_reg)))
        else $error("state changed without an item");

    a_bad_no_change : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == ST_BAD) |=> ($stable(rf_reg) && $stable(ctl_reg.pc)))
        else $error("unsupported instruction changed state");

endmodule

`default_nettype wire

// ===== tb/x86_exec_checker.sv =====
// Checker: predicts each executed instruction and compares the result stream against it.
`timescale 1ns / 1ps

module x86_exec_checker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    input  wire                            s_tready,
    input  wire [x86e_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire [x86e_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire [x86e_pkg::STATUS_W-1:0]   m_tuser,
    output int                             fail_count,
    output int                             pending
);
    import x86e_pkg::*;

    localparam int WORD_REGS = DEFAULT_NUM_REGS;

    typedef struct packed {
        word_t   next_pc;
        status_t status;
        word_t   ax;
        word_t   cx;
        word_t   dx;
        word_t   bx;
    } step_result_t;

    word_t        gpr [WORD_REGS];
    word_t        pc;
    logic         halted;
    step_result_t expected_steps [$];
    step_result_t want;
    step_result_t new_step;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input word_t got, input word_t exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, exp_val));
    endtask

    function automatic byte_t get_byte(input reg_code_t code);
        return code[2] ? gpr[code[1:0]][15:8] : gpr[code[1:0]][7:0];
    endfunction

    function automatic void put_byte(input reg_code_t code, input byte_t v);
        if (code[2])
            gpr[code[1:0]][15:8] = v;
        else
            gpr[code[1:0]][7:0] = v;
    endfunction

    // register-to-register forms; direction bit picks reg as destination
    task automatic apply_modrm(input byte_t opc, input byte_t modrm, input alu_op_t op,
                               output bit ok);
        reg_code_t dst;
        reg_code_t src;
        word_t     a;
        word_t     b;
        byte_t     a8;
        byte_t     b8;
        ok = 1'b0;
        if (modrm[7:6] != MOD_REG)
            return;
        if (opc[1])
        begin
            dst = modrm[5:3];
            src = modrm[2:0];
        end
        else
        begin
            dst = modrm[2:0];
            src = modrm[5:3];
        end
        if (opc[0])
        begin
            if (dst >= WORD_REGS || src >= WORD_REGS)
                return;
            a = gpr[dst];
            b = gpr[src];
            case (op)
                ALU_MOV: gpr[dst] = b;
                ALU_ADD: gpr[dst] = a + b;
                default: gpr[dst] = a - b;
            endcase
        end
        else
        begin
            a8 = get_byte(dst);
            b8 = get_byte(src);
            case (op)
                ALU_MOV: put_byte(dst, b8);
                ALU_ADD: put_byte(dst, a8 + b8);
                default: put_byte(dst, a8 - b8);
            endcase
        end
        ok = 1'b1;
    endtask

    task automatic execute_instruction(input byte_t opc, input byte_t b1, input byte_t b2,
                                       output step_result_t res);
        word_t   imm16;
        status_t st;
        word_t   len;
        bit      ok;
        imm16 = {b2, b1};
        st    = ST_OK;
        len   = '0;
        ok    = 1'b1;
        if (halted)
            st = ST_EXIT;
        else if (opc[7:3] == OPC_MOV_R8_IMM)
        begin
            put_byte(opc[2:0], b1);
            len = 16'd2;
        end
        else if (opc[7:3] == OPC_MOV_R16_IMM)
        begin
            if (opc[2:0] < WORD_REGS)
            begin
                gpr[opc[1:0]] = imm16;
                len = 16'd3;
            end
            else
                st = ST_BAD;
        end
        else if (opc[7:2] == OPC_MOV_MODRM || opc[7:2] == OPC_ADD_MODRM
                 || opc[7:2] == OPC_SUB_MODRM)
        begin
            if (opc[7:2] == OPC_MOV_MODRM)
                apply_modrm(opc, b1, ALU_MOV, ok);
            else if (opc[7:2] == OPC_ADD_MODRM)
                apply_modrm(opc, b1, ALU_ADD, ok);
            else
                apply_modrm(opc, b1, ALU_SUB, ok);
            if (ok)
                len = 16'd2;
            else
                st = ST_BAD;
        end
        else if (opc == OPC_ADD_AL_IMM)
        begin
            put_byte(REG_AX, get_byte(REG_AX) + b1);
            len = 16'd2;
        end
        else if (opc == OPC_SUB_AL_IMM)
        begin
            put_byte(REG_AX, get_byte(REG_AX) - b1);
            len = 16'd2;
        end
        else if (opc == OPC_ADD_AX_IMM)
        begin
            gpr[REG_AX] = gpr[REG_AX] + imm16;
            len = 16'd3;
        end
        else if (opc == OPC_SUB_AX_IMM)
        begin
            gpr[REG_AX] = gpr[REG_AX] - imm16;
            len = 16'd3;
        end
        else if (opc == OPC_LOOP)
        begin
            // decrement first, then test
            gpr[REG_CX] = gpr[REG_CX] - 16'd1;
            pc = pc + 16'd2;
            if (gpr[REG_CX] != '0)
                pc = pc + {{8{b1[7]}}, b1};
        end
        else if (opc == OPC_INT && b1 == INT_EXIT_VEC)
        begin
            halted = 1'b1;
            st     = ST_EXIT;
            len    = 16'd2;
        end
        else
            st = ST_BAD;

        pc  = pc + len;
        res = '{next_pc: pc, status: st, ax: gpr[0], cx: gpr[1], dx: gpr[2], bx: gpr[3]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (gpr[i])
                gpr[i] = '0;
            pc         = '0;
            halted     = 1'b0;
            fail_count = 0;
            expected_steps.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_steps.size() == 0)
                    report_mismatch($sformatf("result item with none expected, tdata %h",
                                              m_tdata));
                else
                begin
                    want = expected_steps.pop_front();
                    check_field("next_pc", m_tdata[15:0], want.next_pc);
                    check_field("status", word_t'(m_tuser), word_t'(want.status));
                    check_field("ax", m_tdata[31:16], want.ax);
                    check_field("cx", m_tdata[47:32], want.cx);
                    check_field("dx", m_tdata[63:48], want.dx);
                    check_field("bx", m_tdata[79:64], want.bx);
                end
            end
            if (s_tvalid && s_tready)
            begin
                execute_instruction(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], new_step);
                expected_steps.push_back(new_step);
            end
            pending <= expected_steps.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import x86e_pkg::*;

    localparam int    RANDOM_ITEMS = 650;
    localparam byte_t OPC_NOP      = 8'h90;
    localparam byte_t INT_DOS_VEC  = 8'h21;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    status_t               m_axis_tuser;
    int                    fail_count;
    int                    pending;

    logic [IN_DATA_W-1:0]  program_items [$];
    int                    ready_mode = 0;
    int                    ready_left = 0;
    int                    ready_phase = 0;

    x86_16bit_register_executor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    x86_exec_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // back-pressure in stretches: always ready, coin toss, mostly stalled, fixed rhythm
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 80);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (ready_phase % 3 != 0);
        endcase
    end

    function automatic logic [IN_DATA_W-1:0] instr(input byte_t opc, input byte_t b1,
                                                   input byte_t b2);
        return {b2, b1, opc};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_instr();
        int        k;
        byte_t     opc;
        byte_t     b1;
        byte_t     b2;
        reg_code_t r;
        reg_code_t m;
        logic [1:0] dw;
        k  = $urandom_range(0, 99);
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
        dw = 2'($urandom_range(0, 3));
        if (k < 12)
            opc = {OPC_MOV_R8_IMM, 3'($urandom_range(0, 7))};
        else if (k < 24)
        begin
            r = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                            : 3'($urandom_range(0, 3));
            opc = {OPC_MOV_R16_IMM, r};
            // small counts so that LOOP falls through now and then
            if (r == REG_CX && $urandom_range(0, 1) == 0)
            begin
                b1 = 8'($urandom_range(0, 3));
                b2 = '0;
            end
        end
        else if (k < 52 || (k >= 78 && k < 88))
        begin
            case ($urandom_range(0, 2))
                0: opc = {OPC_MOV_MODRM, dw};
                1: opc = {OPC_ADD_MODRM, dw};
                default: opc = {OPC_SUB_MODRM, dw};
            endcase
            if (k < 52)
            begin
                r = dw[0] ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
                m = dw[0] ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
                b1 = {MOD_REG, r, m};
            end
        end
        else if (k < 64)
        begin
            case ($urandom_range(0, 3))
                0: opc = OPC_ADD_AL_IMM;
                1: opc = OPC_ADD_AX_IMM;
                2: opc = OPC_SUB_AL_IMM;
                default: opc = OPC_SUB_AX_IMM;
            endcase
        end
        else if (k < 78)
            opc = OPC_LOOP;
        else if (k < 92)
        begin
            opc = OPC_INT;
            if (b1 == INT_EXIT_VEC)
                b1 = INT_DOS_VEC;
        end
        else
        begin
            opc = 8'($urandom_range(0, 255));
            if (opc == OPC_INT && b1 == INT_EXIT_VEC)
                b1 = INT_DOS_VEC;
        end
        return instr(opc, b1, b2);
    endfunction

    task automatic send_item(input logic [IN_DATA_W-1:0] item);
        s_axis_tdata  <= item;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int idx;
        int burst;
        int gap;

        // LOOP with CX at zero: wraps CX and jumps backwards past address zero
        program_items.push_back(instr(OPC_LOOP, 8'h80, 8'h00));
        program_items.push_back(instr({OPC_MOV_R16_IMM, REG_AX}, 8'hFF, 8'hFF));
        program_items.push_back(instr({OPC_MOV_R16_IMM, REG_CX}, 8'h01, 8'h00));
        program_items.push_back(instr({OPC_MOV_R16_IMM, 3'd2}, 8'h34, 8'h12));
        program_items.push_back(instr({OPC_MOV_R16_IMM, 3'd3}, 8'h00, 8'h80));
        program_items.push_back(instr({OPC_MOV_R16_IMM, 3'd4}, 8'h55, 8'hAA));
        program_items.push_back(instr({OPC_MOV_R8_IMM, 3'd0}, 8'h00, 8'hFF));
        program_items.push_back(instr({OPC_MOV_R8_IMM, 3'd7}, 8'hFF, 8'h00));
        // CX goes from one to zero: no jump
        program_items.push_back(instr(OPC_LOOP, 8'h05, 8'h00));
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b00}, 8'hC7, 8'h00));
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b10}, 8'hE2, 8'h00));
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b01}, 8'hD9, 8'h00));
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b11}, 8'hC2, 8'h00));
        // memory operand, then a word register beyond BX
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b11}, 8'h06, 8'h00));
        program_items.push_back(instr({OPC_MOV_MODRM, 2'b01}, 8'hE0, 8'h00));
        program_items.push_back(instr({OPC_ADD_MODRM, 2'b00}, 8'hC4, 8'h00));
        program_items.push_back(instr({OPC_ADD_MODRM, 2'b01}, 8'hD8, 8'h00));
        program_items.push_back(instr({OPC_ADD_MODRM, 2'b10}, 8'hFF, 8'h00));
        program_items.push_back(instr({OPC_ADD_MODRM, 2'b11}, 8'hCB, 8'h00));
        program_items.push_back(instr({OPC_SUB_MODRM, 2'b00}, 8'hC0, 8'h00));
        program_items.push_back(instr({OPC_SUB_MODRM, 2'b01}, 8'hD1, 8'h00));
        program_items.push_back(instr({OPC_SUB_MODRM, 2'b10}, 8'hE5, 8'h00));
        program_items.push_back(instr({OPC_SUB_MODRM, 2'b11}, 8'hC9, 8'h00));
        program_items.push_back(instr(OPC_LOOP, 8'h7F, 8'h00));
        program_items.push_back(instr(OPC_ADD_AL_IMM, 8'hFF, 8'h00));
        program_items.push_back(instr(OPC_ADD_AX_IMM, 8'hFF, 8'hFF));
        program_items.push_back(instr(OPC_SUB_AL_IMM, 8'h80, 8'h00));
        program_items.push_back(instr(OPC_SUB_AX_IMM, 8'h01, 8'h00));
        program_items.push_back(instr(OPC_INT, INT_DOS_VEC, 8'h00));
        program_items.push_back(instr(OPC_NOP, 8'hFF, 8'hFF));

        repeat (RANDOM_ITEMS)
            program_items.push_back(random_instr());

        // exit, then items that must find the core halted
        program_items.push_back(instr(OPC_INT, INT_EXIT_VEC, 8'h00));
        program_items.push_back(instr({OPC_MOV_R8_IMM, 3'd0}, 8'h55, 8'h00));
        program_items.push_back(instr(OPC_LOOP, 8'hF0, 8'h00));
        program_items.push_back(instr(OPC_INT, INT_EXIT_VEC, 8'h00));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < program_items.size())
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < program_items.size())
            begin
                send_item(program_items[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        if (gap == 0)
            s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);

        if (fail_count == 0)
            $display("x86_16bit_register_executor test passed");
        else
            $display("x86_16bit_register_executor test failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("x86_16bit_register_executor test failed");
        $finish;
    end

endmodule
